// File: rtl/dihtbl_pkg.sv
// Shared types and constants of the dual index handle table.
package dihtbl_pkg;

  localparam logic [63:0] GOLDEN     = 64'd11400714819323198485;
  localparam int          MAX_DEPTH  = 8;
  localparam logic [3:0]  TAG_HANDLE = 4'd1;

  typedef enum logic [2:0] {
    CMD_PUT      = 3'd0,
    CMD_GET      = 3'd1,
    CMD_ANCESTOR = 3'd2,
    CMD_DROP     = 3'd3,
    CMD_SUBTREE  = 3'd4,
    CMD_BELOW    = 3'd5,
    CMD_BY_KEY   = 3'd6,
    CMD_CLEAR    = 3'd7
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [3:0]  tag;
    logic [63:0] owner;
    logic [63:0] key;
    logic [63:0] id;
  } entry_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] handle_id;
    logic [63:0] object_key;
    logic [3:0]  type_tag;
    logic [63:0] owner_id;
  } cmd_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
    logic [8:0]  live_entries;
  } rsp_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_req_t;

endpackage

// File: rtl/dihtbl_if.sv
// Valid/ready channel interfaces for commands and responses.
interface dihtbl_cmd_if;
  import dihtbl_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dihtbl_rsp_if;
  import dihtbl_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/dihtbl_ram.sv
// Generic single write port RAM with registered read.
module dihtbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dihtbl_hash.sv
// Multi-cycle Fibonacci hash reduced modulo the table size.
module dihtbl_hash #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dihtbl_pkg::hash_req_t          req_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot_o
);
  import dihtbl_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam logic [AW:0] SLOTS_W = (AW+1)'(TABLE_SLOTS);

  logic          busy_q, done_q;
  logic [3:0]    ph_q;
  logic [63:0]   x_q, prod_q;
  logic [31:0]   acc_q;
  logic [AW-1:0] rem_q, rem_d;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;

  // 64-bit product low half from three 32x32 partial products, one a cycle
  assign mul_a = (ph_q == 4'd1) ? x_q[63:32] : x_q[31:0];
  assign mul_b = (ph_q == 4'd2) ? GOLDEN[63:32] : GOLDEN[31:0];
  assign mul_p = mul_a * mul_b;

  // reduce four bits of the hash a cycle, most significant first
  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem_q;
    for (int k = 0; k < 4; k++) begin
      t = {r, acc_q[31-k]};
      if (t >= SLOTS_W) begin
        t = t - SLOTS_W;
      end
      r = t[AW-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q <= 1'b1;
          ph_q   <= '0;
        end
      end else begin
        ph_q <= ph_q + 4'd1;
        if (ph_q == 4'd11) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      x_q <= req_i.key;
    end else begin
      case (ph_q)
        4'd0: prod_q <= mul_p;
        4'd1: begin
          acc_q  <= prod_q[63:32];
          prod_q <= mul_p;
        end
        4'd2: begin
          acc_q  <= acc_q + prod_q[31:0];
          prod_q <= mul_p;
        end
        4'd3: begin
          acc_q <= acc_q + prod_q[31:0];
          rem_q <= '0;
        end
        default: begin
          rem_q <= rem_d;
          acc_q <= acc_q << 4;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign slot_o = rem_q;

endmodule

// File: rtl/dual_index_handle_table.sv
// Dual index handle table: top level with command sequencer and table memories.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  cmd_i   | in  | valid / ready | command, handle_id, object_key, type_tag, owner_id
//  rsp_o   | out | valid / ready | result_value, status, live_entries
//
// One item is processed at a time. Each lookup costs one shared hash plus its id
// or key probes; ancestor walks and re-filing take up to 8 id lookups more.
// Drops take three passes of TABLE_SLOTS slots (mark, clear, rebuild); marking
// spends up to 8 id lookups per entry and rebuilding two hashes per survivor.
// After reset a clearing pass over all TABLE_SLOTS slots runs before cmd_i is ready.
// The response register lets a new item enter while a result waits on rsp_o.
module dual_index_handle_table #(
  parameter int TABLE_SLOTS = 256,
  parameter int ROOT_SHIFT  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  dihtbl_cmd_if.sink   cmd_i,
  dihtbl_rsp_if.source rsp_o
);
  import dihtbl_pkg::*;

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int IW = AW + 1;
  localparam int EW = $bits(entry_t);
  localparam logic [AW-1:0] LAST = AW'(TABLE_SLOTS - 1);
  localparam int FULL_AT = (3 * TABLE_SLOTS + 3) / 4;
  localparam int SEQ_BITS = (ROOT_SHIFT < 32) ? ROOT_SHIFT : 32;
  localparam logic [63:0] SEQ_MASK = (64'd1 << SEQ_BITS) - 64'd1;

  localparam logic [1:0] SW_ONE   = 2'd0;
  localparam logic [1:0] SW_TREE  = 2'd1;
  localparam logic [1:0] SW_BELOW = 2'd2;

  // sequencer states
  localparam logic [5:0] S_IDLE = 6'd0,  S_DONE = 6'd1,  S_CLR  = 6'd2;
  localparam logic [5:0] S_FH   = 6'd3,  S_FHW  = 6'd4,  S_FRD  = 6'd5,  S_FCK = 6'd6;
  localparam logic [5:0] S_KH   = 6'd7,  S_KHW  = 6'd8,  S_KRD  = 6'd9,  S_KCK = 6'd10;
  localparam logic [5:0] S_KERD = 6'd11, S_KECK = 6'd12;
  localparam logic [5:0] S_UTOP = 6'd13, S_UNXT = 6'd14;
  localparam logic [5:0] S_PK   = 6'd15, S_PUND = 6'd16, S_PF   = 6'd17, S_GF  = 6'd18;
  localparam logic [5:0] S_ATOP = 6'd19, S_AF   = 6'd20, S_DF   = 6'd21, S_DK  = 6'd22;
  localparam logic [5:0] S_MRD  = 6'd23, S_MCK  = 6'd24, S_MUND = 6'd25;
  localparam logic [5:0] S_RCLR = 6'd26, S_RRD  = 6'd27, S_RCK  = 6'd28;
  localparam logic [5:0] S_RIH  = 6'd29, S_RIHW = 6'd30, S_RIRD = 6'd31, S_RICK = 6'd32;
  localparam logic [5:0] S_RKH  = 6'd33, S_RKHW = 6'd34, S_RKRD = 6'd35, S_RKCK = 6'd36;

  // control registers
  logic [5:0]    state_q, state_d, clr_ret_q, clr_ret_d, fid_ret_q, fid_ret_d;
  logic [5:0]    key_ret_q, key_ret_d, und_ret_q, und_ret_d;
  logic [AW-1:0] i_q, i_d;
  logic [IW-1:0] used_q, used_d;
  logic [31:0]   nseq_q, nseq_d, nroot_q, nroot_d;
  logic          act_q, act_d, out_v_q, out_v_d;

  // working registers
  logic [63:0]   hid_q, hid_d, key_q, key_d, own_q, own_d;
  logic [3:0]    tag_q, tag_d;
  logic [63:0]   res_val_q, res_val_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [63:0]   fid_x_q, fid_x_d, walk_id_q, walk_id_d, head_q, head_d;
  logic [63:0]   newid_q, newid_d;
  logic          fnd_q, fnd_d, kfnd_q, kfnd_d, ures_q, ures_d;
  entry_t        fent_q, fent_d, kent_q, kent_d, rent_q, rent_d;
  logic [AW-1:0] p_q, p_d, kslot_q, kslot_d, kq_q, kq_d, ins_q, ins_d;
  logic [3:0]    walk_d_q, walk_d_d;
  logic [1:0]    mode_q, mode_d;
  rsp_item_t     out_q, out_d;

  // memory ports
  logic [EW-1:0] ent_rdata [2];
  logic          ent_we [2];
  logic [AW-1:0] ent_wa [2], ent_ra [2];
  logic [EW-1:0] ent_wd [2];
  entry_t        ract, rnew;
  logic          aw_en, nw_en;
  logic [AW-1:0] aw_addr, nw_addr, act_ra;
  entry_t        aw_data, nw_data;
  logic          kx_we;
  logic [AW-1:0] kx_wa;
  logic [IW-1:0] kx_wd, kx_rd;
  logic          mk_we, mk_wd, mk_rd;

  hash_req_t     hreq;
  logic          h_done;
  logic [AW-1:0] h_slot;

  // put: id formation
  logic [63:0]   root_v, seq_v, nseq_v, id_v;
  logic          table_full;

  assign ract = entry_t'(ent_rdata[act_q]);
  assign rnew = entry_t'(ent_rdata[~act_q]);

  // Two entry banks: lookups use the active bank; a drop rebuilds into the other.
  for (genvar b = 0; b < 2; b++) begin : g_bank
    assign ent_we[b] = (1'(b) == act_q) ? aw_en : nw_en;
    assign ent_wa[b] = (1'(b) == act_q) ? aw_addr : nw_addr;
    assign ent_wd[b] = (1'(b) == act_q) ? EW'(aw_data) : EW'(nw_data);
    assign ent_ra[b] = (1'(b) == act_q) ? act_ra : p_q;
    dihtbl_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ent (
      .clk_i   (clk_i),
      .we_i    (ent_we[b]),
      .waddr_i (ent_wa[b]),
      .wdata_i (ent_wd[b]),
      .raddr_i (ent_ra[b]),
      .rdata_o (ent_rdata[b])
    );
  end

  // key index: slot + 1 of the entry filed under a (key, tag), 0 when empty
  dihtbl_ram #(.WIDTH(IW), .DEPTH(TABLE_SLOTS)) u_kidx (
    .clk_i   (clk_i),
    .we_i    (kx_we),
    .waddr_i (kx_wa),
    .wdata_i (kx_wd),
    .raddr_i (kq_q),
    .rdata_o (kx_rd)
  );

  // drop marks, judged on the table as it stood before the drop
  dihtbl_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_mark (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (i_q),
    .wdata_i (mk_wd),
    .raddr_i (i_q),
    .rdata_o (mk_rd)
  );

  dihtbl_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .done_o (h_done),
    .slot_o (h_slot)
  );

  assign root_v = (own_q != 64'd0) ? (own_q >> ROOT_SHIFT) :
                  (tag_q == TAG_HANDLE) ? {32'd0, nroot_q} : 64'd0;
  assign seq_v  = {32'd0, nseq_q} & SEQ_MASK;
  assign nseq_v = (seq_v + 64'd1) & SEQ_MASK;
  assign id_v   = (root_v << ROOT_SHIFT) | seq_v;
  assign table_full = ({1'b0, used_q} + (IW+1)'(1)) >= (IW+1)'(FULL_AT);

  // active bank read address by state
  always_comb begin
    case (state_q)
      S_FRD:   act_ra = p_q;
      S_KERD:  act_ra = kslot_q;
      default: act_ra = i_q;
    endcase
  end

  assign cmd_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

  always_comb begin
    state_d   = state_q;   clr_ret_d = clr_ret_q; fid_ret_d = fid_ret_q;
    key_ret_d = key_ret_q; und_ret_d = und_ret_q; i_d       = i_q;
    used_d    = used_q;    nseq_d    = nseq_q;    nroot_d   = nroot_q;
    act_d     = act_q;     out_v_d   = out_v_q;
    hid_d     = hid_q;     key_d     = key_q;
    own_d     = own_q;     tag_d     = tag_q;     res_val_d = res_val_q;
    res_st_d  = res_st_q;  fid_x_d   = fid_x_q;   walk_id_d = walk_id_q;
    head_d    = head_q;    newid_d   = newid_q;   fnd_d     = fnd_q;
    kfnd_d    = kfnd_q;    ures_d    = ures_q;    fent_d    = fent_q;
    kent_d    = kent_q;    rent_d    = rent_q;    p_d       = p_q;
    kslot_d   = kslot_q;   kq_d      = kq_q;      ins_d     = ins_q;
    walk_d_d  = walk_d_q;  mode_d    = mode_q;    out_d     = out_q;

    aw_en = 1'b0; aw_addr = i_q; aw_data = '0;
    nw_en = 1'b0; nw_addr = i_q; nw_data = '0;
    kx_we = 1'b0; kx_wa   = i_q; kx_wd   = '0;
    mk_we = 1'b0; mk_wd   = 1'b0;
    hreq  = '0;

    // drain the response register
    if (out_v_q && rsp_o.ready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          hid_d     = cmd_i.payload.handle_id;
          key_d     = cmd_i.payload.object_key;
          tag_d     = cmd_i.payload.type_tag;
          own_d     = cmd_i.payload.owner_id;
          res_val_d = '0;
          res_st_d  = ST_OK;
          unique case (cmd_e'(cmd_i.payload.command))
            CMD_PUT: begin
              if (cmd_i.payload.object_key == 64'd0) begin
                res_st_d = ST_MISS;
                state_d  = S_DONE;
              end else begin
                key_ret_d = S_PK;
                state_d   = S_KH;
              end
            end
            CMD_GET: begin
              fid_x_d   = cmd_i.payload.handle_id;
              fid_ret_d = S_GF;
              state_d   = S_FH;
            end
            CMD_ANCESTOR: begin
              walk_id_d = cmd_i.payload.handle_id;
              res_val_d = cmd_i.payload.handle_id;
              walk_d_d  = '0;
              state_d   = S_ATOP;
            end
            CMD_DROP: begin
              fid_x_d   = cmd_i.payload.handle_id;
              fid_ret_d = S_DF;
              state_d   = S_FH;
            end
            CMD_SUBTREE, CMD_BELOW: begin
              if (cmd_i.payload.owner_id == 64'd0) begin
                res_st_d = ST_MISS;
                state_d  = S_DONE;
              end else begin
                head_d  = cmd_i.payload.owner_id;
                mode_d  = (cmd_e'(cmd_i.payload.command) == CMD_SUBTREE) ? SW_TREE
                                                                        : SW_BELOW;
                i_d     = '0;
                state_d = S_MRD;
              end
            end
            CMD_BY_KEY: begin
              key_ret_d = S_DK;
              state_d   = S_KH;
            end
            CMD_CLEAR: begin
              i_d       = '0;
              clr_ret_d = S_DONE;
              state_d   = S_CLR;
            end
          endcase
        end
      end

      S_DONE: begin
        // hold until the response register is free
        if (!out_v_q || rsp_o.ready) begin
          out_d.result_value = res_val_q;
          out_d.status       = res_st_q;
          out_d.live_entries = 9'(used_q);
          out_v_d            = 1'b1;
          state_d            = S_IDLE;
        end
      end

      // clearing pass over the active bank and the key index
      S_CLR: begin
        aw_en = 1'b1;
        kx_we = 1'b1;
        if (i_q == LAST) begin
          i_d     = '0;
          used_d  = '0;
          state_d = clr_ret_q;
        end else begin
          i_d = i_q + AW'(1);
        end
      end

      // find by id: hash, then probe until empty or match
      S_FH: begin
        if (fid_x_q == 64'd0) begin
          fnd_d   = 1'b0;
          state_d = fid_ret_q;
        end else begin
          hreq.start = 1'b1;
          hreq.key   = fid_x_q;
          state_d    = S_FHW;
        end
      end
      S_FHW: begin
        if (h_done) begin
          p_d     = h_slot;
          state_d = S_FRD;
        end
      end
      S_FRD: state_d = S_FCK;
      S_FCK: begin
        if (ract.id == 64'd0) begin
          fnd_d   = 1'b0;
          state_d = fid_ret_q;
        end else if (ract.id == fid_x_q) begin
          fnd_d   = 1'b1;
          fent_d  = ract;
          state_d = fid_ret_q;
        end else begin
          p_d     = (p_q == LAST) ? '0 : p_q + AW'(1);
          state_d = S_FRD;
        end
      end

      // find by (key, tag) through the key index
      S_KH: begin
        if (key_q == 64'd0) begin
          kfnd_d  = 1'b0;
          state_d = key_ret_q;
        end else begin
          hreq.start = 1'b1;
          hreq.key   = key_q ^ (64'(tag_q) << 56);
          state_d    = S_KHW;
        end
      end
      S_KHW: begin
        if (h_done) begin
          kq_d    = h_slot;
          state_d = S_KRD;
        end
      end
      S_KRD: state_d = S_KCK;
      S_KCK: begin
        if (kx_rd == '0) begin
          kfnd_d  = 1'b0;
          state_d = key_ret_q;
        end else begin
          kslot_d = AW'(kx_rd - IW'(1));
          state_d = S_KERD;
        end
      end
      S_KERD: state_d = S_KECK;
      S_KECK: begin
        if (ract.key == key_q && ract.tag == tag_q) begin
          kfnd_d  = 1'b1;
          kent_d  = ract;
          state_d = key_ret_q;
        end else begin
          kq_d    = (kq_q == LAST) ? '0 : kq_q + AW'(1);
          state_d = S_KRD;
        end
      end

      // ancestry test: walk owners from walk_id toward head
      S_UTOP: begin
        if (walk_id_q == 64'd0 || walk_d_q == 4'(MAX_DEPTH)) begin
          ures_d  = 1'b0;
          state_d = und_ret_q;
        end else if (walk_id_q == head_q) begin
          ures_d  = 1'b1;
          state_d = und_ret_q;
        end else begin
          fid_x_d   = walk_id_q;
          fid_ret_d = S_UNXT;
          state_d   = S_FH;
        end
      end
      S_UNXT: begin
        walk_id_d = fnd_q ? fent_q.owner : 64'd0;
        walk_d_d  = walk_d_q + 4'd1;
        state_d   = S_UTOP;
      end

      // put
      S_PK: begin
        if (kfnd_q) begin
          if (own_q != 64'd0 && own_q != kent_q.owner) begin
            walk_id_d = own_q;
            walk_d_d  = '0;
            head_d    = kent_q.owner;
            und_ret_d = S_PUND;
            state_d   = S_UTOP;
          end else begin
            res_val_d = kent_q.id;
            state_d   = S_DONE;
          end
        end else if (table_full) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          // advance the counters even if the id turns out unusable
          if (own_q == 64'd0 && tag_q == TAG_HANDLE) begin
            nroot_d = nroot_q + 32'd1;
          end
          nseq_d  = (nseq_v == 64'd0) ? 32'd1 : nseq_v[31:0];
          newid_d = id_v;
          if (id_v == 64'd0) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            fid_x_d   = id_v;
            fid_ret_d = S_PF;
            state_d   = S_FH;
          end
        end
      end
      S_PUND: begin
        // re-file under the closer owner
        if (ures_q) begin
          aw_en         = 1'b1;
          aw_addr       = kslot_q;
          aw_data       = kent_q;
          aw_data.owner = own_q;
        end
        res_val_d = kent_q.id;
        state_d   = S_DONE;
      end
      S_PF: begin
        if (fnd_q) begin
          res_st_d = ST_FULL;
        end else begin
          aw_en     = 1'b1;
          aw_addr   = p_q;
          aw_data   = '{tag: tag_q, owner: own_q, key: key_q, id: newid_q};
          kx_we     = 1'b1;
          kx_wa     = kq_q;
          kx_wd     = IW'({1'b0, p_q}) + IW'(1);
          used_d    = used_q + IW'(1);
          res_val_d = newid_q;
        end
        state_d = S_DONE;
      end

      S_GF: begin
        if (fnd_q && fent_q.tag == tag_q) begin
          res_val_d = fent_q.key;
        end else begin
          res_st_d = ST_MISS;
        end
        state_d = S_DONE;
      end

      // ancestor walk; res_val holds the topmost id found so far
      S_ATOP: begin
        if (walk_id_q == 64'd0 || walk_d_q == 4'(MAX_DEPTH)) begin
          if (walk_d_q == '0) begin
            res_st_d = ST_MISS;
          end
          state_d = S_DONE;
        end else begin
          fid_x_d   = walk_id_q;
          fid_ret_d = S_AF;
          state_d   = S_FH;
        end
      end
      S_AF: begin
        if (!fnd_q) begin
          if (walk_d_q == '0) begin
            res_st_d = ST_MISS;
          end
          state_d = S_DONE;
        end else begin
          res_val_d = walk_id_q;
          if (tag_q != 4'd0 && fent_q.tag == tag_q) begin
            state_d = S_DONE;
          end else begin
            walk_id_d = fent_q.owner;
            walk_d_d  = walk_d_q + 4'd1;
            state_d   = S_ATOP;
          end
        end
      end

      S_DF: begin
        if (fnd_q) begin
          head_d  = hid_q;
          mode_d  = SW_ONE;
          i_d     = '0;
          state_d = S_MRD;
        end else begin
          res_st_d = ST_MISS;
          state_d  = S_DONE;
        end
      end
      S_DK: begin
        if (kfnd_q) begin
          head_d  = kent_q.id;
          mode_d  = SW_TREE;
          i_d     = '0;
          state_d = S_MRD;
        end else begin
          res_st_d = ST_MISS;
          state_d  = S_DONE;
        end
      end

      // mark pass over the old table
      S_MRD: state_d = S_MCK;
      S_MCK: begin
        if (ract.id == 64'd0 || mode_q == SW_ONE ||
            (mode_q == SW_BELOW && ract.id == head_q)) begin
          mk_we = 1'b1;
          mk_wd = (mode_q == SW_ONE) && (ract.id == head_q) && (ract.id != 64'd0);
          if (i_q == LAST) begin
            i_d     = '0;
            state_d = S_RCLR;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_MRD;
          end
        end else begin
          walk_id_d = ract.id;
          walk_d_d  = '0;
          und_ret_d = S_MUND;
          state_d   = S_UTOP;
        end
      end
      S_MUND: begin
        mk_we = 1'b1;
        mk_wd = ures_q;
        if (i_q == LAST) begin
          i_d     = '0;
          state_d = S_RCLR;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = S_MRD;
        end
      end

      // clear the spare bank and the key index
      S_RCLR: begin
        nw_en = 1'b1;
        kx_we = 1'b1;
        if (i_q == LAST) begin
          i_d     = '0;
          used_d  = '0;
          state_d = S_RRD;
        end else begin
          i_d = i_q + AW'(1);
        end
      end

      // rebuild: re-insert survivors into the spare bank in slot order
      S_RRD: state_d = S_RCK;
      S_RCK: begin
        if (ract.id == 64'd0 || mk_rd) begin
          if (i_q == LAST) begin
            act_d   = ~act_q;
            state_d = S_DONE;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_RRD;
          end
        end else begin
          rent_d  = ract;
          state_d = S_RIH;
        end
      end
      S_RIH: begin
        hreq.start = 1'b1;
        hreq.key   = rent_q.id;
        state_d    = S_RIHW;
      end
      S_RIHW: begin
        if (h_done) begin
          p_d     = h_slot;
          state_d = S_RIRD;
        end
      end
      S_RIRD: state_d = S_RICK;
      S_RICK: begin
        if (rnew.id == 64'd0) begin
          nw_en   = 1'b1;
          nw_addr = p_q;
          nw_data = rent_q;
          ins_d   = p_q;
          state_d = S_RKH;
        end else begin
          p_d     = (p_q == LAST) ? '0 : p_q + AW'(1);
          state_d = S_RIRD;
        end
      end
      S_RKH: begin
        hreq.start = 1'b1;
        hreq.key   = rent_q.key ^ (64'(rent_q.tag) << 56);
        state_d    = S_RKHW;
      end
      S_RKHW: begin
        if (h_done) begin
          kq_d    = h_slot;
          state_d = S_RKRD;
        end
      end
      S_RKRD: state_d = S_RKCK;
      S_RKCK: begin
        if (kx_rd == '0) begin
          kx_we  = 1'b1;
          kx_wa  = kq_q;
          kx_wd  = IW'({1'b0, ins_q}) + IW'(1);
          used_d = used_q + IW'(1);
          if (i_q == LAST) begin
            act_d   = ~act_q;
            state_d = S_DONE;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = S_RRD;
          end
        end else begin
          kq_d    = (kq_q == LAST) ? '0 : kq_q + AW'(1);
          state_d = S_RKRD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_ret_q <= S_IDLE;
      fid_ret_q <= S_IDLE;
      key_ret_q <= S_IDLE;
      und_ret_q <= S_IDLE;
      i_q       <= '0;
      used_q    <= '0;
      nseq_q    <= 32'd1;
      nroot_q   <= 32'd1;
      act_q     <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ret_q <= clr_ret_d;
      fid_ret_q <= fid_ret_d;
      key_ret_q <= key_ret_d;
      und_ret_q <= und_ret_d;
      i_q       <= i_d;
      used_q    <= used_d;
      nseq_q    <= nseq_d;
      nroot_q   <= nroot_d;
      act_q     <= act_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hid_q     <= hid_d;
    key_q     <= key_d;
    own_q     <= own_d;
    tag_q     <= tag_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    fid_x_q   <= fid_x_d;
    walk_id_q <= walk_id_d;
    head_q    <= head_d;
    newid_q   <= newid_d;
    fnd_q     <= fnd_d;
    kfnd_q    <= kfnd_d;
    ures_q    <= ures_d;
    fent_q    <= fent_d;
    kent_q    <= kent_d;
    rent_q    <= rent_d;
    p_q       <= p_d;
    kslot_q   <= kslot_d;
    kq_q      <= kq_d;
    ins_q     <= ins_d;
    walk_d_q  <= walk_d_d;
    mode_q    <= mode_d;
    out_q     <= out_d;
  end

endmodule
